### src/atia_pkg.sv
package atia_pkg;

  localparam logic [31:0] ID_BASE_RESET = 32'd1000;

  localparam logic OP_LOOKUP  = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DECIDE  = 6'b000010,
    ST_SCAN    = 6'b000100,
    ST_MISS    = 6'b001000,
    ST_PRELOAD = 6'b010000,
    ST_UNUSED  = 6'b100000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic fin_hit;
    logic fin_miss;
    logic fin_preload;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_preload;
    logic empty;
    logic hit;
    logic last_cmp;
  } sts_t;

endpackage

### src/atia_ctrl.sv
module atia_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  atia_pkg::sts_t sts,
  output atia_pkg::cmd_t cmd,
  output logic           busy
);

  atia_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atia_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      atia_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = atia_pkg::ST_DECIDE;
        end
      end
      atia_pkg::ST_DECIDE: begin
        priority if (sts.op_preload) begin
          state_nxt = atia_pkg::ST_PRELOAD;
        end else if (sts.empty) begin
          state_nxt = atia_pkg::ST_MISS;
        end else begin
          state_nxt = atia_pkg::ST_SCAN;
        end
      end
      atia_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        priority if (sts.hit) begin
          cmd.fin_hit = 1'b1;
          state_nxt   = atia_pkg::ST_IDLE;
        end else if (sts.last_cmp) begin
          state_nxt = atia_pkg::ST_MISS;
        end
      end
      atia_pkg::ST_MISS: begin
        cmd.fin_miss = 1'b1;
        state_nxt    = atia_pkg::ST_IDLE;
      end
      atia_pkg::ST_PRELOAD: begin
        cmd.fin_preload = 1'b1;
        state_nxt       = atia_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = atia_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != atia_pkg::ST_IDLE);

endmodule

### src/atia_dp.sv
module atia_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  atia_pkg::cmd_t cmd,
  output atia_pkg::sts_t sts,
  input  logic           in_operation,
  input  logic [63:0]    in_ext_address,
  input  logic [31:0]    in_preload_id,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  output logic           out_valid,
  output logic [31:0]    out_device_number,
  output logic           out_newly_assigned,
  output logic           out_status
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  logic [63:0] mem_addr [TABLE_ENTRIES];
  logic [31:0] mem_num  [TABLE_ENTRIES];

  logic             op_r;
  logic [63:0]      key_r;
  logic [31:0]      pid_r;
  logic [CNT_W-1:0] fill_r;
  logic [31:0]      last_r, last_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             pend_r;
  logic [63:0]      rd_addr_q;
  logic [31:0]      rd_num_q;

  logic             out_valid_r;
  logic [31:0]      out_num_r;
  logic             out_new_r;
  logic             out_full_r;

  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             full;
  logic             do_write;
  logic [31:0]      wr_num;

  assign last_idx = IDX_W'(fill_r - CNT_W'(1));
  assign wr_idx   = fill_r[IDX_W-1:0];
  assign full     = (fill_r == FULL_CNT);
  assign do_write = (cmd.fin_miss || cmd.fin_preload) && !full;
  assign wr_num   = cmd.fin_preload ? pid_r : (last_r + 32'd1);

  always_comb begin
    last_nxt = last_r;
    if (do_write) begin
      if (cmd.fin_preload) begin
        if (last_r < pid_r) begin
          last_nxt = pid_r;
        end
      end else begin
        last_nxt = last_r + 32'd1;
      end
    end
  end

  // table storage, one write port at the fill index, one registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem_addr[wr_idx] <= key_r;
      mem_num[wr_idx]  <= wr_num;
    end
    rd_addr_q <= mem_addr[rd_idx_r];
    rd_num_q  <= mem_num[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      key_r <= in_ext_address;
      pid_r <= in_preload_id;
    end
    cmp_idx_r <= rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      last_r   <= atia_pkg::ID_BASE_RESET;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_r <= cfg_wdata;
      end else begin
        last_r <= last_nxt;
      end
      if (do_write) begin
        fill_r <= fill_r + CNT_W'(1);
      end
      if (cmd.load) begin
        rd_idx_r <= '0;
        pend_r   <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= 1'b1;
        if (rd_idx_r != last_idx) begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin_hit || cmd.fin_miss || cmd.fin_preload;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.fin_hit) begin
      out_num_r  <= rd_num_q;
      out_new_r  <= 1'b0;
      out_full_r <= 1'b0;
    end else if (cmd.fin_miss || cmd.fin_preload) begin
      out_num_r  <= full ? 32'd0 : wr_num;
      out_new_r  <= !full;
      out_full_r <= full;
    end else begin
      out_num_r  <= out_num_r;
      out_new_r  <= out_new_r;
      out_full_r <= out_full_r;
    end
  end

  assign sts.op_preload = (op_r == atia_pkg::OP_PRELOAD);
  assign sts.empty      = (fill_r == '0);
  assign sts.hit        = pend_r && (rd_addr_q == key_r);
  assign sts.last_cmp   = pend_r && (cmp_idx_r == last_idx);

  assign out_valid          = out_valid_r;
  assign out_device_number  = out_num_r;
  assign out_newly_assigned = out_new_r;
  assign out_status         = out_full_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond table size");

  a_fill_grows_with_new: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> (out_valid_r && out_new_r))
    else $error("entry appended without a new-entry result");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held over two cycles");

  a_full_not_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (!out_new_r && (out_num_r == 32'd0)))
    else $error("full result carries an entry");

endmodule

### src/address_to_id_assign_table.sv
// address to device number table with id allocation
//
// input beat: start high while busy is low hands over in_operation,
// in_ext_address and in_preload_id. lookup (operation 0) scans the filled
// entries in insertion order, one entry per cycle through the table's
// registered read port; a miss appends the address with the next counter
// value. preload (operation 1) appends the given pair without a duplicate
// check, raising the counter to that id if larger; no append when full.
// result beat: out_valid is high for exactly one cycle with the device
// number, the new-entry flag and the full status. the receiver cannot
// stall, so results are never held off.
// sequence: a preload passes the decide and preload states before the
// strobe; a lookup passes decide, then scans over the table's registered
// read port until a hit or the last filled entry (then the miss state),
// and an empty table goes from decide to the miss state. busy drops as
// the strobe rises.
// config: cfg_we loads cfg_wdata as the id base and so resets the counter;
// the user must write it only while idle; the block does not enforce it.
// reset: synchronous, rst_n low empties the table (fill count zero) and
// loads the counter with 1000; no clearing pass is needed.
module address_to_id_assign_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [63:0] in_ext_address,
  input  logic [31:0] in_preload_id,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [31:0] out_device_number,
  output logic        out_newly_assigned,
  output logic        out_status
);

  atia_pkg::cmd_t cmd;
  atia_pkg::sts_t sts;

  // sequencer: decides preload, scan or append and issues one finish command
  atia_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table memory, fill count, id counter and result registers
  atia_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_ext_address     (in_ext_address),
    .in_preload_id      (in_preload_id),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_device_number  (out_device_number),
    .out_newly_assigned (out_newly_assigned),
    .out_status         (out_status)
  );

endmodule
